// ===== hw/rtl/rrq_pkg.sv =====
// ============================================================================
// rrq_pkg
// Shared types, codes and constants of the range reading qualifier.
// ============================================================================
package rrq_pkg;

    localparam int DIST_BITS      = 13;
    localparam int RANGE_BITS     = 16;
    localparam int TIME_BITS      = 32;
    localparam int FAIL_BITS      = 8;
    localparam int ALPHA_BITS     = 9;
    localparam int ALPHA_SHIFT    = 8;
    localparam int GAP_BITS       = 16;
    localparam int OUT_COUNT_BITS = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int QUEUE_DEPTH    = 2;

    localparam int FRAC_BITS_DEFAULT  = 8;
    localparam int COUNT_BITS_DEFAULT = 16;

    localparam logic [RANGE_BITS-1:0] CLEAR_LEVEL = 16'd8190;
    localparam logic [FAIL_BITS-1:0]  FAIL_SAT    = 8'd255;
    localparam logic [ALPHA_BITS-1:0] ALPHA_ONE   = 9'd256;

    localparam logic [ALPHA_BITS-1:0] ALPHA_RESET     = 9'd77;
    localparam logic [DIST_BITS-1:0]  MAX_STEP_RESET  = 13'd500;
    localparam logic [FAIL_BITS-1:0]  THRESHOLD_RESET = 8'd2;
    localparam logic [GAP_BITS-1:0]   GAP_RESET       = 16'd500;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ALPHA     = 2'd0,
        CFG_MAX_STEP  = 2'd1,
        CFG_THRESHOLD = 2'd2,
        CFG_RETRY_GAP = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_CLEAR   = 2'd1,
        ST_TIMEOUT = 2'd2,
        ST_ERROR   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ACT_NONE       = 2'd0,
        ACT_PROBE_FAIL = 2'd1,
        ACT_LIGHT      = 2'd2,
        ACT_FULL       = 2'd3
    } action_t;

    // Classification that the front end can make without the back-end state.
    typedef enum logic [2:0] {
        CLS_LINK_FAIL,
        CLS_TIMEOUT,
        CLS_ZERO,
        CLS_CLEAR,
        CLS_VALID
    } poll_class_t;

    typedef struct packed {
        poll_class_t           cls;
        logic [TIME_BITS-1:0]  now_ms;
        logic [RANGE_BITS-1:0] range_mm;
        logic                  probe_ok;
        logic                  restart_ok;
    } poll_entry_t;

    typedef struct packed {
        logic push;
        logic full;
    } queue_wr_t;

    typedef struct packed {
        logic valid;
        logic pop;
    } queue_rd_t;

endpackage

// ===== hw/rtl/rrq_if.sv =====
// ============================================================================
// rrq_poll_if / rrq_result_if
// Valid/ready channels for poll transactions and result transactions.
// ============================================================================
interface rrq_poll_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        link_ok;
    logic        timed_out;
    logic [15:0] range_mm;
    logic        probe_ok;
    logic        restart_ok;

    modport source (output valid, now_ms, link_ok, timed_out, range_mm, probe_ok, restart_ok,
                    input ready);
    modport sink (input valid, now_ms, link_ok, timed_out, range_mm, probe_ok, restart_ok,
                  output ready);
endinterface

interface rrq_result_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [1:0]  status_code;
    logic [15:0] raw_mm;
    logic [12:0] filtered_mm;
    logic [7:0]  fail_run;
    logic [15:0] attempt_total;
    logic [15:0] recovery_total;
    logic [1:0]  recovery_action;
    logic [31:0] last_good_ms;

    modport source (output valid, accepted, status_code, raw_mm, filtered_mm, fail_run,
                    attempt_total, recovery_total, recovery_action, last_good_ms,
                    input ready);
    modport sink (input valid, accepted, status_code, raw_mm, filtered_mm, fail_run,
                  attempt_total, recovery_total, recovery_action, last_good_ms,
                  output ready);
endinterface

// ===== hw/rtl/rrq_front.sv =====
// ============================================================================
// rrq_front
// Accepts poll transactions and classifies the reading for the back end.
// ============================================================================
module rrq_front
    import rrq_pkg::*;
(
    rrq_poll_if.sink    poll,
    input  logic        queue_full,
    output queue_wr_t   wr,
    output poll_entry_t entry
);

    always_comb
    begin
        entry.now_ms     = poll.now_ms;
        entry.range_mm   = poll.range_mm;
        entry.probe_ok   = poll.probe_ok;
        entry.restart_ok = poll.restart_ok;
        // Link loss outranks a timeout, which outranks the reading itself.
        priority if (!poll.link_ok)
            entry.cls = CLS_LINK_FAIL;
        else if (poll.timed_out)
            entry.cls = CLS_TIMEOUT;
        else if (poll.range_mm >= CLEAR_LEVEL)
            entry.cls = CLS_CLEAR;
        else if (poll.range_mm == '0)
            entry.cls = CLS_ZERO;
        else
            entry.cls = CLS_VALID;
    end

    assign poll.ready = !queue_full;
    assign wr.push    = poll.valid && !queue_full;
    assign wr.full    = queue_full;

endmodule

// ===== hw/rtl/rrq_queue.sv =====
// ============================================================================
// rrq_queue
// Short FIFO of classified polls between the front end and the back end.
// ============================================================================
module rrq_queue
    import rrq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  queue_wr_t   wr,
    input  poll_entry_t wr_entry,
    output logic        full,
    input  logic        pop,
    output queue_rd_t   rd,
    output poll_entry_t rd_entry
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    poll_entry_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    do_pop;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign do_pop   = pop && (count_reg != '0);
    assign rd.valid = (count_reg != '0);
    assign rd.pop   = do_pop;
    assign rd_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr.push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr.push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !wr.push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
            slot_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

// ===== hw/rtl/rrq_back.sv =====
// ============================================================================
// rrq_back
// Applies one classified poll per cycle, unless a result waits untaken,
// to the failure, recovery and filter state and registers the result.
// ============================================================================
module rrq_back
    import rrq_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEFAULT,
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  queue_rd_t                 rd,
    input  poll_entry_t               entry,
    output logic                      pop,
    rrq_result_if.source              result
);

    localparam int SW = DIST_BITS + FRAC_BITS;
    localparam int PW = SW + 1 + ALPHA_BITS + 1;

    logic [ALPHA_BITS-1:0] alpha_reg;
    logic [DIST_BITS-1:0]  max_step_reg;
    logic [FAIL_BITS-1:0]  threshold_reg;
    logic [GAP_BITS-1:0]   gap_reg;

    logic                  ready_flag_reg, ready_flag_next;
    logic [FAIL_BITS-1:0]  fail_reg, fail_next;
    logic                  pending_reg, pending_next;
    logic [COUNT_BITS-1:0] attempt_reg, attempt_next;
    logic [COUNT_BITS-1:0] success_reg, success_next;
    logic [TIME_BITS-1:0]  last_attempt_reg, last_attempt_next;
    logic                  empty_reg, empty_next;
    logic [SW-1:0]         smooth_reg, smooth_next;
    status_t               status_reg, status_next;
    logic [RANGE_BITS-1:0] raw_reg, raw_next;
    logic [TIME_BITS-1:0]  last_good_reg, last_good_next;

    logic                  out_valid_reg;
    logic                  ok;
    action_t               action;

    logic [ALPHA_BITS-1:0] alpha_eff;
    logic [SW-1:0]         cur;
    logic signed [SW:0]    diff;
    logic signed [SW:0]    step_s;
    logic signed [SW:0]    diff_lim;
    logic signed [PW-1:0]  prod;
    logic signed [PW-1:0]  blend;

    assign pop = rd.valid && (!out_valid_reg || result.ready);

    // Filter datapath: slew limit on the difference, then one multiply.
    assign alpha_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign cur       = {entry.range_mm[DIST_BITS-1:0], {FRAC_BITS{1'b0}}};
    assign diff      = $signed({1'b0, cur}) - $signed({1'b0, smooth_reg});
    assign step_s    = $signed({1'b0, max_step_reg, {FRAC_BITS{1'b0}}});

    always_comb
    begin
        priority if (diff > step_s)
            diff_lim = step_s;
        else if (diff < -step_s)
            diff_lim = -step_s;
        else
            diff_lim = diff;
    end

    assign prod  = $signed({1'b0, alpha_eff}) * diff_lim;
    assign blend = prod >>> ALPHA_SHIFT;

    always_comb
    begin
        logic fail_now;
        status_t fail_code;

        ready_flag_next   = ready_flag_reg;
        fail_next         = fail_reg;
        pending_next      = pending_reg;
        attempt_next      = attempt_reg;
        success_next      = success_reg;
        last_attempt_next = last_attempt_reg;
        empty_next        = empty_reg;
        smooth_next       = smooth_reg;
        status_next       = status_reg;
        raw_next          = raw_reg;
        last_good_next    = last_good_reg;
        ok                = 1'b0;
        action            = ACT_NONE;
        fail_now          = 1'b0;
        fail_code         = ST_ERROR;

        if (pop)
        begin
            if (!ready_flag_reg || entry.cls == CLS_LINK_FAIL)
            begin
                fail_now  = 1'b1;
                fail_code = ST_ERROR;
            end
            else if (entry.cls == CLS_TIMEOUT)
            begin
                fail_now  = 1'b1;
                fail_code = ST_TIMEOUT;
            end
            else
            begin
                raw_next = entry.range_mm;
                if (entry.cls == CLS_ZERO)
                begin
                    fail_now  = 1'b1;
                    fail_code = ST_ERROR;
                end
                else
                begin
                    ok             = 1'b1;
                    last_good_next = entry.now_ms;
                    fail_next      = '0;
                    if (pending_reg)
                    begin
                        pending_next = 1'b0;
                        empty_next   = 1'b1;
                        success_next = success_reg + 1'b1;
                    end
                    if (entry.cls == CLS_CLEAR)
                        status_next = ST_CLEAR;
                    else
                    begin
                        status_next = ST_VALID;
                        if (empty_next)
                        begin
                            empty_next  = 1'b0;
                            smooth_next = cur;
                        end
                        else
                            smooth_next = smooth_reg + blend[SW-1:0];
                    end
                end
            end

            if (fail_now)
            begin
                status_next = fail_code;
                if (fail_reg != FAIL_SAT)
                    fail_next = fail_reg + 1'b1;
                if (fail_next >= threshold_reg &&
                    (entry.now_ms - last_attempt_reg) >= {{(TIME_BITS-GAP_BITS){1'b0}}, gap_reg})
                begin
                    last_attempt_next = entry.now_ms;
                    attempt_next      = attempt_reg + 1'b1;
                    if (!entry.probe_ok)
                    begin
                        ready_flag_next = 1'b0;
                        action          = ACT_PROBE_FAIL;
                    end
                    else
                    begin
                        ready_flag_next = entry.restart_ok;
                        if (entry.restart_ok)
                            pending_next = 1'b1;
                        else
                            status_next = ST_ERROR;
                        action = attempt_next[0] ? ACT_LIGHT : ACT_FULL;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg        <= ALPHA_RESET;
            max_step_reg     <= MAX_STEP_RESET;
            threshold_reg    <= THRESHOLD_RESET;
            gap_reg          <= GAP_RESET;
            ready_flag_reg   <= 1'b1;
            fail_reg         <= '0;
            pending_reg      <= 1'b0;
            attempt_reg      <= '0;
            success_reg      <= '0;
            last_attempt_reg <= '0;
            empty_reg        <= 1'b1;
            smooth_reg       <= '0;
            status_reg       <= ST_ERROR;
            raw_reg          <= '0;
            last_good_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_ALPHA:     alpha_reg     <= cfg_data[ALPHA_BITS-1:0];
                    CFG_MAX_STEP:  max_step_reg  <= cfg_data[DIST_BITS-1:0];
                    CFG_THRESHOLD: threshold_reg <= cfg_data[FAIL_BITS-1:0];
                    CFG_RETRY_GAP: gap_reg       <= cfg_data[GAP_BITS-1:0];
                    default:       alpha_reg     <= alpha_reg;
                endcase
            end
            ready_flag_reg   <= ready_flag_next;
            fail_reg         <= fail_next;
            pending_reg      <= pending_next;
            attempt_reg      <= attempt_next;
            success_reg      <= success_next;
            last_attempt_reg <= last_attempt_next;
            empty_reg        <= empty_next;
            smooth_reg       <= smooth_next;
            status_reg       <= status_next;
            raw_reg          <= raw_next;
            last_good_reg    <= last_good_next;
            if (pop)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload register; loaded with the state after each poll.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result.accepted        <= ok;
            result.status_code     <= status_next;
            result.raw_mm          <= raw_next;
            result.filtered_mm     <= smooth_next[SW-1:FRAC_BITS];
            result.fail_run        <= fail_next;
            result.attempt_total   <= OUT_COUNT_BITS'(attempt_next);
            result.recovery_total  <= OUT_COUNT_BITS'(success_next);
            result.recovery_action <= action;
            result.last_good_ms    <= last_good_next;
        end
    end

    assign result.valid = out_valid_reg;

endmodule

// ===== hw/rtl/range_reading_qualifier.sv =====
// ============================================================================
// range_reading_qualifier
// Qualifies distance-sensor polls, filters valid readings and grants
// recovery attempts after repeated failures.
// ============================================================================
// The block takes one poll transaction per clock cycle while the queue has
// room and returns exactly one result transaction for each, in order. The
// front end classifies a poll in the cycle it is accepted and writes it into
// the queue at the accepting edge. Once the poll is at the head of the queue
// and the output register is free or being taken, the back end applies it to
// the state and loads the output register. The sustained rate of one poll per
// cycle while results are taken is set by the back end's state update, whose
// longest path is the slew limiter followed by the low-pass multiply and add.
// While a result waits to be taken, the two-entry queue still accepts up to
// two more polls; after that the poll side stalls until the result is taken.
// Configuration writes take effect at the clock edge of the write and are
// meant to be made while no poll is in flight.
module range_reading_qualifier
    import rrq_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEFAULT,
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    rrq_poll_if.sink                  poll,
    rrq_result_if.source              result,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    queue_wr_t   wr;
    queue_rd_t   rd;
    poll_entry_t wr_entry;
    poll_entry_t rd_entry;
    logic        queue_full;
    logic        pop;

    // Front end: classifies the link, timeout and range of each poll.
    rrq_front u_front (
        .poll       (poll),
        .queue_full (queue_full),
        .wr         (wr),
        .entry      (wr_entry)
    );

    // Queue: decouples poll acceptance from result back-pressure.
    rrq_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .wr_entry (wr_entry),
        .full     (queue_full),
        .pop      (pop),
        .rd       (rd),
        .rd_entry (rd_entry)
    );

    // Back end: failure counting, recovery grants, filter and result register.
    rrq_back #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rd        (rd),
        .entry     (rd_entry),
        .pop       (pop),
        .result    (result)
    );

endmodule
